@@ hdl/star_mask_string_match_unit_macros.svh @@
// assertion macros for the matcher rtl file
`ifndef STAR_MASK_STRING_MATCH_UNIT_MACROS_SVH
`define STAR_MASK_STRING_MATCH_UNIT_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define SMM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("smm assertion failed");
// checked on every edge, reset included
`define SMM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("smm assertion failed");
`else
`define SMM_ASSERT(lbl, clk, rst, prop)
`define SMM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/smm_pkg.sv @@
`timescale 1ns / 1ps
package smm_pkg;

  // mask store size and derived widths
  localparam int MASK_MAX = 32;
  localparam int LEN_W    = $clog2(MASK_MAX + 2);
  localparam int IDX_W    = $clog2(MASK_MAX);

  localparam logic [7:0] STAR = 8'h2A;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_MASK   = 2'd1,
    FUNC_STRING = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  // request to the tail compare unit
  typedef struct packed {
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] len;
    logic             exact_case;
  } tail_ctl_t;

  // ascii upper to lower when folding
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

endpackage

@@ hdl/smm_ifs.sv @@
`timescale 1ns / 1ps
// input channel: one command item
interface smm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_byte;

  modport source (output valid, output func, output char_byte, input ready);
  modport sink   (input valid, input func, input char_byte, output ready);
endinterface

// output channel: one match result item
interface smm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic mask_overflow;

  modport source (output valid, output matched, output mask_overflow, input ready);
  modport sink   (input valid, input matched, input mask_overflow, output ready);
endinterface

@@ hdl/smm_tail_cmp.sv @@
`timescale 1ns / 1ps
// compares the newest n window bytes with mask bytes 1..n
module smm_tail_cmp (
  input  logic [7:0]        window [smm_pkg::MASK_MAX],
  input  logic [7:0]        mask   [smm_pkg::MASK_MAX],
  input  smm_pkg::tail_ctl_t ctl,
  output logic              equal
);
  import smm_pkg::*;

  logic [MASK_MAX*8-1:0] flat;
  logic [MASK_MAX*8-1:0] aligned;
  logic [LEN_W-1:0]      sh;
  logic [MASK_MAX-2:0]   ok;
  logic                  n_fits;
  logic                  len_fits;

  // flatten, newest byte at the top
  always_comb begin
    for (int p = 0; p < MASK_MAX; p++) begin
      flat[p*8 +: 8] = window[p];
    end
  end

  // bring the oldest of the n bytes down to position 0
  assign sh      = LEN_W'(MASK_MAX) - ctl.n;
  assign aligned = flat >> {sh, 3'b000};

  // per-byte compare, positions past n always pass
  always_comb begin
    for (int i = 0; i < MASK_MAX - 1; i++) begin
      ok[i] = (LEN_W'(i) >= ctl.n) ||
              (fold_byte(aligned[i*8 +: 8], ctl.exact_case) ==
               fold_byte(mask[i+1], ctl.exact_case));
    end
  end

  assign n_fits   = ctl.n <= LEN_W'(MASK_MAX - 1);
  assign len_fits = ({1'b0, ctl.n} + (LEN_W+1)'(1)) <= {1'b0, ctl.len};
  assign equal    = (&ok) && n_fits && len_fits;

endmodule

@@ hdl/star_mask_string_match_unit.sv @@
`timescale 1ns / 1ps
// Wildcard mask matcher, stars honored only at the ends of the mask.
// Input channel in_ch carries func and char_byte: clear, append a mask byte,
// append a string byte, or end the string. Only an end-of-string item makes
// a result item on out_ch: matched and mask_overflow.
// cfg_we / cfg_wdata write the exact-case mode (1 after reset); write it
// while no item is in flight.
// Every item passes an input register and is then applied to the state; the
// result lands in an output register. The result of an end-of-string item
// passes the input register and then the output register before it shows valid.
// Throughput is one item per cycle while out_ch takes results, set by the
// combinational window compare (barrel align of the 32-byte string window plus 31 byte compares).
// When out_ch stalls with a result held, a following end-of-string item
// waits in the input register and in_ch.ready drops; other items go on.
// Synchronous reset clears the mask length, string state, overflow flag and
// the valid bits of both registers; mask store contents are left as they are.
module star_mask_string_match_unit (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  smm_in_if.sink    in_ch,
  smm_out_if.source out_ch
);
  import smm_pkg::*;
  `include "star_mask_string_match_unit_macros.svh"

  // configuration
  logic exact_case;

  // input register
  logic       s1_valid;
  func_t      s1_func;
  logic [7:0] s1_byte;
  logic       s1_fire;

  // block state
  logic [7:0]       mask_store [MASK_MAX];
  logic [LEN_W-1:0] mask_length;
  logic             last_star_r;
  logic [7:0]       window [MASK_MAX];
  logic [LEN_W-1:0] string_length;
  logic             prefix_equal;
  logic             inner_found;
  logic             overflow_flag;

  logic [LEN_W-1:0] mask_length_next;
  logic             last_star_next;
  logic [LEN_W-1:0] string_length_next;
  logic             prefix_equal_next;
  logic             inner_found_next;
  logic             overflow_flag_next;
  logic             window_shift;
  logic             window_clear;
  logic             mask_write;

  // output register
  logic out_valid;
  logic matched;
  logic mask_overflow;
  logic out_valid_next;
  logic decide;

  // derived values
  logic             lead_star;
  logic             last_star;
  logic [LEN_W-1:0] cmp_len;
  logic [LEN_W-1:0] sl_inc;
  logic [7:0]       pos_byte;
  logic [7:0]       win_shifted [MASK_MAX];
  logic [7:0]       tail_win [MASK_MAX];
  tail_ctl_t        tail_ctl;
  logic             tail_equal;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_case <= 1'b1;
    end else if (cfg_we) begin
      exact_case <= cfg_wdata;
    end
  end

  // input register handshake
  assign s1_fire     = s1_valid && (s1_func != FUNC_END || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func <= func_t'(in_ch.func);
      s1_byte <= in_ch.char_byte;
    end
  end

  // mask shape
  assign lead_star = (mask_length != '0) && (mask_store[0] == STAR);
  assign last_star = (mask_length != '0) && last_star_r;
  assign cmp_len   = last_star ? mask_length - LEN_W'(1) : mask_length;
  assign sl_inc    = (string_length < LEN_W'(MASK_MAX + 1)) ?
                     string_length + LEN_W'(1) : string_length;
  assign pos_byte  = mask_store[string_length[IDX_W-1:0]];

  // window after taking the current byte
  always_comb begin
    for (int p = 0; p < MASK_MAX - 1; p++) begin
      win_shifted[p] = window[p+1];
    end
    win_shifted[MASK_MAX-1] = s1_byte;
  end

  // tail compare, shared by inner search and suffix decision
  always_comb begin
    tail_ctl.len        = mask_length;
    tail_ctl.exact_case = exact_case;
    if (s1_func == FUNC_STRING) begin
      tail_ctl.n = mask_length - LEN_W'(2);
      tail_win   = win_shifted;
    end else begin
      tail_ctl.n = mask_length - LEN_W'(1);
      tail_win   = window;
    end
  end

  smm_tail_cmp u_tail (
    .window (tail_win),
    .mask   (mask_store),
    .ctl    (tail_ctl),
    .equal  (tail_equal)
  );

  // match decision at end of string
  always_comb begin
    decide = 1'b0;
    priority if (mask_length == '0) begin
      decide = 1'b0;
    end else if (mask_length == LEN_W'(1) && mask_store[0] == STAR) begin
      decide = 1'b1;
    end else if (lead_star || last_star) begin
      priority if (({1'b0, string_length} + (LEN_W+1)'(1)) < {1'b0, mask_length}) begin
        decide = 1'b0;
      end else if (lead_star && !last_star) begin
        decide = tail_equal;
      end else if (!lead_star && last_star) begin
        decide = prefix_equal;
      end else begin
        decide = (mask_length == LEN_W'(2)) || inner_found;
      end
    end else begin
      decide = (string_length == mask_length) && prefix_equal;
    end
  end

  // next state of the matcher
  always_comb begin
    mask_length_next   = mask_length;
    last_star_next     = last_star_r;
    string_length_next = string_length;
    prefix_equal_next  = prefix_equal;
    inner_found_next   = inner_found;
    overflow_flag_next = overflow_flag;
    window_shift       = 1'b0;
    window_clear       = 1'b0;
    mask_write         = 1'b0;
    if (s1_fire) begin
      unique case (s1_func)
        FUNC_CLEAR: begin
          mask_length_next   = '0;
          last_star_next     = 1'b0;
          overflow_flag_next = 1'b0;
          window_clear       = 1'b1;
        end
        FUNC_MASK: begin
          window_clear = 1'b1;
          if (mask_length < LEN_W'(MASK_MAX)) begin
            mask_write       = 1'b1;
            mask_length_next = mask_length + LEN_W'(1);
            last_star_next   = (s1_byte == STAR);
          end else begin
            overflow_flag_next = 1'b1;
          end
        end
        FUNC_STRING: begin
          window_shift       = 1'b1;
          string_length_next = sl_inc;
          if (string_length < cmp_len &&
              fold_byte(s1_byte, exact_case) != fold_byte(pos_byte, exact_case)) begin
            prefix_equal_next = 1'b0;
          end
          if (lead_star && last_star && mask_length >= LEN_W'(3) &&
              sl_inc >= mask_length - LEN_W'(2) && tail_equal) begin
            inner_found_next = 1'b1;
          end
        end
        FUNC_END: begin
          window_clear = 1'b1;
        end
      endcase
      if (window_clear) begin
        string_length_next = '0;
        prefix_equal_next  = 1'b1;
        inner_found_next   = 1'b0;
      end
    end
  end

  // matcher state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length   <= '0;
      last_star_r   <= 1'b0;
      string_length <= '0;
      prefix_equal  <= 1'b1;
      inner_found   <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      mask_length   <= mask_length_next;
      last_star_r   <= last_star_next;
      string_length <= string_length_next;
      prefix_equal  <= prefix_equal_next;
      inner_found   <= inner_found_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  // string window, newest byte at the top
  always_ff @(posedge clk) begin
    if (rst || window_clear) begin
      for (int p = 0; p < MASK_MAX; p++) window[p] <= '0;
    end else if (window_shift) begin
      window <= win_shifted;
    end
  end

  // mask store, contents undefined until written
  always_ff @(posedge clk) begin
    if (mask_write) begin
      mask_store[mask_length[IDX_W-1:0]] <= s1_byte;
    end
  end

  // result register
  always_comb begin
    out_valid_next = out_valid;
    if (s1_fire && s1_func == FUNC_END) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_func == FUNC_END) begin
      matched       <= !overflow_flag && decide;
      mask_overflow <= overflow_flag;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.matched       = matched;
  assign out_ch.mask_overflow = mask_overflow;

  // checks on the matcher state and result path
  `SMM_ASSERT(a_mask_len_range, clk, rst, mask_length <= LEN_W'(MASK_MAX))
  `SMM_ASSERT(a_str_len_range, clk, rst, string_length <= LEN_W'(MASK_MAX + 1))
  `SMM_ASSERT(a_ovf_full_mask, clk, rst, overflow_flag |-> mask_length == LEN_W'(MASK_MAX))
  `SMM_ASSERT(a_ovf_no_match, clk, rst, (out_valid && mask_overflow) |-> !matched)
  `SMM_ASSERT(a_result_from_end, clk, rst, $rose(out_valid) |-> $past(s1_fire && s1_func == FUNC_END))
  `SMM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!out_valid && !s1_valid))

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import smm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic matched;
    logic mask_overflow;
  } verdict_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  star_mask_string_match_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // matcher state as the block should hold it
  logic             case_exact;
  logic [7:0]       mask_bytes [MASK_MAX];
  logic [LEN_W-1:0] mask_count;
  logic [7:0]       text_window [MASK_MAX];
  logic [LEN_W-1:0] text_count;
  logic             head_agrees;
  logic             inner_seen;
  logic             mask_spill;

  verdict_t expected_verdicts [$];

  // mask bytes sent since the last clear, for building strings that hit
  logic [7:0] loaded_mask [$];

  bit idling_enabled;
  int out_hold = 0;
  int cycle_count;
  int fail_count = 0;
  int items_sent;
  int verdicts_checked = 0;
  int matches_seen = 0;
  int overflows_seen = 0;
  int mode_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // letter folding when the case mode is off
  function automatic logic [7:0] fold_letter(logic [7:0] c);
    if (!case_exact && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic bit bytes_equal(logic [7:0] a, logic [7:0] b);
    return fold_letter(a) == fold_letter(b);
  endfunction

  function automatic bit mask_leads_star();
    return mask_count > 0 && mask_bytes[0] == STAR;
  endfunction

  function automatic bit mask_ends_star();
    return mask_count > 0 && mask_bytes[mask_count - 1] == STAR;
  endfunction

  // newest n string bytes against mask bytes from index 1
  function automatic bit window_tail_matches(int unsigned n);
    if (n > MASK_MAX - 1 || n + 1 > mask_count) return 1'b0;
    for (int i = 0; i < n; i++)
      if (!bytes_equal(text_window[MASK_MAX - n + i], mask_bytes[1 + i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_text_state();
    foreach (text_window[i]) text_window[i] = 8'h00;
    text_count  = '0;
    head_agrees = 1'b1;
    inner_seen  = 1'b0;
  endfunction

  function automatic void absorb_text_byte(logic [7:0] c);
    int unsigned cmp_len;
    int unsigned k;
    cmp_len = mask_ends_star() ? mask_count - 1 : mask_count;
    if (text_count < cmp_len && !bytes_equal(c, mask_bytes[text_count])) head_agrees = 1'b0;
    for (int i = 0; i < MASK_MAX - 1; i++) text_window[i] = text_window[i + 1];
    text_window[MASK_MAX - 1] = c;
    if (text_count < MASK_MAX + 1) text_count++;
    if (mask_leads_star() && mask_ends_star() && mask_count >= 3) begin
      k = mask_count - 2;
      if (text_count >= k && window_tail_matches(k)) inner_seen = 1'b1;
    end
  endfunction

  function automatic bit string_matches_mask();
    bit ls;
    bit ts;
    if (mask_count == 0) return 1'b0;
    if (mask_count == 1 && mask_bytes[0] == STAR) return 1'b1;
    ls = mask_leads_star();
    ts = mask_ends_star();
    if (ls || ts) begin
      if (text_count + 1 < mask_count) return 1'b0;
      if (ls && !ts) return window_tail_matches(mask_count - 1);
      if (!ls && ts) return head_agrees;
      return mask_count == 2 || inner_seen;
    end
    return text_count == mask_count && head_agrees;
  endfunction

  // apply one accepted item, queue the verdict it causes
  function automatic void apply_item(func_t f, logic [7:0] c);
    verdict_t v;
    case (f)
      FUNC_CLEAR: begin
        mask_count = '0;
        mask_spill = 1'b0;
        clear_text_state();
      end
      FUNC_MASK: begin
        clear_text_state();
        if (mask_count < MASK_MAX) begin
          mask_bytes[mask_count] = c;
          mask_count++;
        end else begin
          mask_spill = 1'b1;
        end
      end
      FUNC_STRING: absorb_text_byte(c);
      FUNC_END: begin
        v.matched       = !mask_spill && string_matches_mask();
        v.mask_overflow = mask_spill;
        expected_verdicts.push_back(v);
        clear_text_state();
      end
    endcase
  endfunction

  // drive one item and wait for it to be taken
  task automatic send_item(func_t f, logic [7:0] c);
    if (idling_enabled && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.char_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    apply_item(f, c);
    if (f == FUNC_CLEAR) loaded_mask.delete();
    if (f == FUNC_MASK) loaded_mask.push_back(c);
  endtask

  // stop sending and let every queued verdict come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_case_mode(logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we     <= 1'b0;
    case_exact  = mode;
    mode_writes++;
  endtask

  // compare each result item with the oldest verdict
  task automatic check_verdict(logic matched, logic mask_overflow);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result item: matched %0b mask_overflow %0b", matched, mask_overflow);
      fail_count++;
    end else begin
      v = expected_verdicts.pop_front();
      verdicts_checked++;
      if (v.matched) matches_seen++;
      if (v.mask_overflow) overflows_seen++;
      if (matched !== v.matched) begin
        $error("matched: expected %0b, actual %0b", v.matched, matched);
        fail_count++;
      end
      if (mask_overflow !== v.mask_overflow) begin
        $error("mask_overflow: expected %0b, actual %0b", v.mask_overflow, mask_overflow);
        fail_count++;
      end
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) check_verdict(out_ch.matched, out_ch.mask_overflow);
    if (out_hold != 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(1, 13) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return STAR;
      2, 3: return 8'("A" + $urandom_range(0, 1));
      default: return 8'("a" + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic int pick_pad();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 40);
    return $urandom_range(0, 3);
  endfunction

  // empty mask, lone star, field extremes
  task automatic test_empty_and_lone_star();
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_MASK, STAR);
    send_item(FUNC_END, 8'hFF);
    wait_idle();
  endtask

  // "**": needs at least one string byte, zero byte is ordinary
  task automatic test_double_star();
    send_item(FUNC_MASK, STAR);
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_STRING, 8'h00);
    send_item(FUNC_END, 8'h00);
    wait_idle();
  endtask

  // case mode flipped between two bytes of one string
  task automatic test_case_mode_mid_string();
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_MASK, "A");
    send_item(FUNC_MASK, STAR);
    send_item(FUNC_STRING, "a");
    wait_idle();
    write_case_mode(1'b0);
    send_item(FUNC_STRING, "Z");
    send_item(FUNC_END, 8'h00);
    send_item(FUNC_STRING, "a");
    send_item(FUNC_END, 8'h00);
    wait_idle();
  endtask

  // mask byte after string bytes restarts the string; inner star is literal
  task automatic test_mask_after_string();
    send_item(FUNC_STRING, 8'hFF);
    send_item(FUNC_MASK, "b");
    send_item(FUNC_STRING, "a");
    send_item(FUNC_STRING, STAR);
    send_item(FUNC_STRING, "B");
    send_item(FUNC_END, 8'h00);
    wait_idle();
    write_case_mode(1'b1);
  endtask

  // load a mask, then stream strings built to hit or nearly hit it
  task automatic send_match_sequence();
    logic [7:0] text [$];
    logic [7:0] ch;
    int unsigned body_len;
    int unsigned mlen;
    int unsigned split;
    bit lead;
    bit trail;
    if ($urandom_range(0, 5) != 0) send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    lead  = 1'($urandom_range(0, 1));
    trail = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0: body_len = 0;
      1: body_len = $urandom_range(MASK_MAX - 3, MASK_MAX + 2);
      default: body_len = $urandom_range(1, 6);
    endcase
    if (lead) send_item(FUNC_MASK, STAR);
    repeat (body_len) send_item(FUNC_MASK, pick_char());
    if (trail) send_item(FUNC_MASK, STAR);

    repeat ($urandom_range(1, 3)) begin
      mlen  = loaded_mask.size() > MASK_MAX ? MASK_MAX : loaded_mask.size();
      lead  = mlen > 0 && loaded_mask[0] == STAR;
      trail = mlen > 0 && loaded_mask[mlen - 1] == STAR;
      text.delete();
      if (lead || mlen == 0) repeat (pick_pad()) text.push_back(pick_char());
      for (int i = int'(lead); i < int'(mlen) - int'(trail); i++) begin
        ch = loaded_mask[i];
        if (((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) && $urandom_range(0, 1))
          ch = ch ^ 8'h20;
        text.push_back(ch);
      end
      if (trail) repeat (pick_pad()) text.push_back(pick_char());
      // near misses
      if ($urandom_range(0, 3) == 0 && text.size() > 0)
        text[$urandom_range(0, text.size() - 1)] = pick_char();
      if ($urandom_range(0, 7) == 0 && text.size() > 0) void'(text.pop_back());
      split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, text.size()) : text.size() + 1;
      foreach (text[i]) begin
        if (i == split) begin
          wait_idle();
          write_case_mode(1'($urandom_range(0, 1)));
        end
        send_item(FUNC_STRING, text[i]);
      end
      send_item(FUNC_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed sequences, some noise and mode changes
  task automatic test_random_traffic(int item_goal);
    int first;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 4))
             send_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        1: begin
          wait_idle();
          write_case_mode(1'($urandom_range(0, 1)));
        end
        default: send_match_sequence();
      endcase
    end
    wait_idle();
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_CLEAR;
    in_ch.char_byte <= 8'h00;
    items_sent       = 0;
    mode_writes      = 0;
    idling_enabled   = 1'b1;

    // state after reset
    case_exact = 1'b1;
    foreach (mask_bytes[i]) mask_bytes[i] = 8'h00;
    mask_count = '0;
    mask_spill = 1'b0;
    clear_text_state();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_lone_star();
    test_double_star();
    test_case_mode_mid_string();
    test_mask_after_string();
    test_random_traffic(390);
    idling_enabled = 1'b0;
    test_random_traffic(60);
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d match results (%0d matched, %0d mask overflow)",
             items_sent, verdicts_checked, matches_seen, overflows_seen);
    $display("case mode written %0d times, with and without stalls", mode_writes);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/smm_pkg.sv
hdl/smm_ifs.sv
hdl/smm_tail_cmp.sv
hdl/star_mask_string_match_unit.sv
verif/tb.sv
